// ----- rtl/core/lrc_pkg.sv -----
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared constants and types for the LRU region cache core.
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    // Default number of slots and width of byte quantities.
    localparam int ENTRIES_DEFAULT   = 16;
    localparam int BYTE_BITS_DEFAULT = 40;

    // Reset value of the capacity register.
    localparam longint unsigned CAP_RESET = 64'd16777216;

    // Widths of the fixed result fields.
    localparam int EVN_W  = 5;
    localparam int EVT_W  = 32;
    localparam int KIND_W = 2;

    // Configuration port geometry (one register at address zero on a 64-bit data bus).
    localparam int          PADDR_W   = 4;
    localparam int          PDATA_W   = 64;
    localparam logic [3:0]  ADDR_CAP  = 4'd0;

    // Control handed from the sequencer to each cell.
    typedef struct packed {
        logic shift;  // take the neighbor's entry this cycle
        logic valid;  // this cell holds a resident entry
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_EVICT = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrc_cell.sv -----
// ----------------------------------------------------------------------------
// lrc_cell
// One slot of the recency chain: holds an entry, compares it with the
// current word and takes the entry of its more recent neighbor on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_cell #(
    parameter int BYTE_BITS = lrc_pkg::BYTE_BITS_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire lrc_pkg::cell_ctl_t        ctl,
    input  wire logic [lrc_pkg::KIND_W-1:0] prev_kind,
    input  wire logic [BYTE_BITS-1:0]      prev_offset,
    input  wire logic [BYTE_BITS-1:0]      prev_length,
    input  wire logic [lrc_pkg::KIND_W-1:0] key_kind,
    input  wire logic [BYTE_BITS-1:0]      key_offset,
    input  wire logic [BYTE_BITS-1:0]      key_length,
    output logic [lrc_pkg::KIND_W-1:0]     kind,
    output logic [BYTE_BITS-1:0]           offset,
    output logic [BYTE_BITS-1:0]           length,
    output logic                           match
);

    logic [lrc_pkg::KIND_W-1:0] kind_reg;
    logic [BYTE_BITS-1:0]       offset_reg;
    logic [BYTE_BITS-1:0]       length_reg;

    // Entry storage; payload only, so no reset.
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            kind_reg   <= prev_kind;
            offset_reg <= prev_offset;
            length_reg <= prev_length;
        end
    end

    // Full tag compare against the word under lookup.
    assign match = ctl.valid && (kind_reg == key_kind) && (offset_reg == key_offset)
                   && (length_reg == key_length);

    assign kind   = kind_reg;
    assign offset = offset_reg;
    assign length = length_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lru_region_cache_byte_capacity_core.sv -----
// ----------------------------------------------------------------------------
// lru_region_cache_byte_capacity_core
// Fully associative LRU cache of byte regions bounded by a byte capacity and
// by a slot count, built as a chain of cells ordered from most to least
// recently used.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    region kind, offset, size
//   m_       out        m_valid/m_ready    hit, inserted, evictions, occupancy
//   apb      in         psel/penable       capacity_bytes at address 0
//
// A hit's result is valid in the state after the lookup; a miss passes
// through the eviction state, which drops one least recently used entry
// per cycle and then inserts the word unless it exceeds the capacity. One
// word is in flight at a time and s_ready returns in the cycle after the
// result is taken. A stalled result holds until m_ready.
// aresetn is synchronous, holds s_ready low and clears the valid count and
// all counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_region_cache_byte_capacity_core #(
    parameter int ENTRIES   = lrc_pkg::ENTRIES_DEFAULT,
    parameter int BYTE_BITS = lrc_pkg::BYTE_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lrc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [lrc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // Input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lrc_pkg::KIND_W-1:0]    s_region_kind,
    input  wire logic [BYTE_BITS-1:0]          s_region_offset,
    input  wire logic [BYTE_BITS-1:0]          s_region_size,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic                               m_inserted,
    output logic [lrc_pkg::EVN_W-1:0]          m_evicted_now,
    output logic [BYTE_BITS-1:0]               m_occupancy,
    output logic [BYTE_BITS-1:0]               m_peak_occupancy,
    output logic [lrc_pkg::EVT_W-1:0]          m_eviction_total
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
    localparam logic [lrc_pkg::EVN_W-1:0] EVN_MAX = '1;
    localparam logic [lrc_pkg::EVT_W-1:0] EVT_MAX = '1;

    lrc_pkg::state_t state_reg, state_next;

    logic [BYTE_BITS-1:0]       cap_reg;
    logic [lrc_pkg::KIND_W-1:0] kind_reg;
    logic [BYTE_BITS-1:0]       offset_reg;
    logic [BYTE_BITS-1:0]       size_reg;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [BYTE_BITS-1:0]       res_reg, res_next;
    logic [BYTE_BITS-1:0]       peak_reg, peak_next;
    logic [lrc_pkg::EVT_W-1:0]  evt_reg, evt_next;
    logic [lrc_pkg::EVN_W-1:0]  evn_reg, evn_next;
    logic                       hit_reg, hit_next;
    logic                       ins_reg, ins_next;

    // Cell chain wiring; index 0 is the most recent.
    logic [lrc_pkg::KIND_W-1:0] c_kind   [ENTRIES];
    logic [BYTE_BITS-1:0]       c_offset [ENTRIES];
    logic [BYTE_BITS-1:0]       c_length [ENTRIES];
    logic [ENTRIES-1:0]         c_match;
    lrc_pkg::cell_ctl_t         c_ctl    [ENTRIES];

    logic                       shift_hit;
    logic                       shift_all;
    logic                       cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == lrc_pkg::ADDR_CAP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= BYTE_BITS'(lrc_pkg::CAP_RESET);
        end else if (cfg_wr) begin
            cap_reg <= pwdata[BYTE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == lrc_pkg::ADDR_CAP) begin
            prdata[BYTE_BITS-1:0] = cap_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 takes the word under service, so a hit moves the
    // entry to the front and an insertion pushes every entry back by one.
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            logic [lrc_pkg::KIND_W-1:0] p_kind;
            logic [BYTE_BITS-1:0]       p_offset;
            logic [BYTE_BITS-1:0]       p_length;

            if (gi == 0) begin : g_head
                assign p_kind   = kind_reg;
                assign p_offset = offset_reg;
                assign p_length = size_reg;
            end else begin : g_body
                assign p_kind   = c_kind[gi-1];
                assign p_offset = c_offset[gi-1];
                assign p_length = c_length[gi-1];
            end

            // On a hit, cells up to and including the matching one shift.
            assign c_ctl[gi].shift = shift_all || (shift_hit && ((c_match >> gi) != '0));
            assign c_ctl[gi].valid = (CNT_W'(gi) < cnt_reg);

            lrc_cell #(
                .BYTE_BITS (BYTE_BITS)
            ) u_cell (
                .aclk        (aclk),
                .ctl         (c_ctl[gi]),
                .prev_kind   (p_kind),
                .prev_offset (p_offset),
                .prev_length (p_length),
                .key_kind    (kind_reg),
                .key_offset  (offset_reg),
                .key_length  (size_reg),
                .kind        (c_kind[gi]),
                .offset      (c_offset[gi]),
                .length      (c_length[gi]),
                .match       (c_match[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Captured word.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg   <= s_region_kind;
            offset_reg <= s_region_offset;
            size_reg   <= s_region_size;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: lookup; a miss then evicts or inserts, one per cycle.
    logic [BYTE_BITS:0]   need;
    logic                 over_cap;
    logic                 too_big;
    logic [IDX_W-1:0]     lru_idx;
    logic [BYTE_BITS-1:0] lru_len;
    logic [BYTE_BITS-1:0] res_ins;

    assign need     = {1'b0, res_reg} + {1'b0, size_reg};
    assign over_cap = need > {1'b0, cap_reg};
    assign too_big  = size_reg > cap_reg;
    assign lru_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign lru_len  = c_length[lru_idx];
    assign res_ins  = need[BYTE_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        peak_next  = peak_reg;
        evt_next   = evt_reg;
        evn_next   = evn_reg;
        hit_next   = hit_reg;
        ins_next   = ins_reg;
        shift_hit  = 1'b0;
        shift_all  = 1'b0;

        case (state_reg)
            lrc_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = lrc_pkg::ST_LOOK;
                end
            end
            lrc_pkg::ST_LOOK: begin
                hit_next = |c_match;
                ins_next = 1'b0;
                evn_next = '0;
                if (|c_match) begin
                    shift_hit  = 1'b1;
                    state_next = lrc_pkg::ST_OUT;
                end else begin
                    state_next = lrc_pkg::ST_EVICT;
                end
            end
            lrc_pkg::ST_EVICT: begin
                if ((over_cap && cnt_reg != '0) || (!too_big && cnt_reg == CNT_FULL)) begin
                    // Drop the least recently used entry.
                    cnt_next = cnt_reg - CNT_W'(1);
                    res_next = (res_reg >= lru_len) ? (res_reg - lru_len) : '0;
                    if (evn_reg != EVN_MAX) begin
                        evn_next = evn_reg + lrc_pkg::EVN_W'(1);
                    end
                    if (evt_reg != EVT_MAX) begin
                        evt_next = evt_reg + lrc_pkg::EVT_W'(1);
                    end
                end else if (too_big) begin
                    state_next = lrc_pkg::ST_OUT;
                end else begin
                    // Insert at the front of the chain.
                    shift_all  = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    res_next   = res_ins;
                    if (res_ins > peak_reg) begin
                        peak_next = res_ins;
                    end
                    ins_next   = 1'b1;
                    state_next = lrc_pkg::ST_OUT;
                end
            end
            lrc_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = lrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            res_reg   <= '0;
            peak_reg  <= '0;
            evt_reg   <= '0;
            evn_reg   <= '0;
            hit_reg   <= 1'b0;
            ins_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            res_reg   <= res_next;
            peak_reg  <= peak_next;
            evt_reg   <= evt_next;
            evn_reg   <= evn_next;
            hit_reg   <= hit_next;
            ins_reg   <= ins_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and result word; no word is taken while in reset.
    assign s_ready          = aresetn && (state_reg == lrc_pkg::ST_IDLE);
    assign m_valid          = (state_reg == lrc_pkg::ST_OUT);
    assign m_hit            = hit_reg;
    assign m_inserted       = ins_reg;
    assign m_evicted_now    = evn_reg;
    assign m_occupancy      = res_reg;
    assign m_peak_occupancy = peak_reg;
    assign m_eviction_total = evt_reg;

endmodule

`default_nettype wire
